// File: rtl/core/twfs_pkg.sv
// Shared types and constants for the ramped speed and wall steering block.
package twfs_pkg;

    localparam int DELTA_HISTORY = 4;
    localparam int C_PTR_W       = $clog2(DELTA_HISTORY);

    localparam int C_SPEED_W = 16;
    localparam int C_ERR_W   = 13;
    localparam int C_ACCEL_W = 15;
    localparam int C_GAIN_W  = 16;
    localparam int C_DELTA_W = C_ERR_W + 1;
    localparam int C_SUM_W   = C_DELTA_W + C_PTR_W;
    localparam int C_PROD_W  = C_ERR_W + C_GAIN_W;
    localparam int C_TOTAL_W = C_PROD_W + 1;
    localparam int C_MAG_W   = C_PROD_W - 1;

    localparam int C_STEER_DIV = 100;
    localparam int C_SUM_SCALE = C_STEER_DIV / DELTA_HISTORY;
    localparam int C_SCALED_W  = C_SUM_W + 5;

    // Exact reciprocal of the steering divisor for magnitudes below 2**C_MAG_W.
    localparam int      C_RECIP_SHIFT = C_MAG_W + 7;
    localparam int      C_RECIP_W     = 29;
    localparam longint  C_RECIP_VAL   =
        ((64'sd1 <<< C_RECIP_SHIFT) + C_STEER_DIV - 1) / C_STEER_DIV;
    localparam int      C_FULL_W      = C_MAG_W + C_RECIP_W;
    localparam int      C_QUOT_W      = 22;

    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 16;

    typedef logic signed [C_SPEED_W-1:0] t_speed;
    typedef logic signed [C_ERR_W-1:0]   t_err;
    typedef logic signed [C_PROD_W-1:0]  t_prod;
    typedef logic signed [C_SUM_W-1:0]   t_sum;
    typedef logic        [C_QUOT_W-1:0]  t_quot;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_ENABLE       = 3'd0,
        CFG_TARGET_SPEED = 3'd1,
        CFG_ACCEL_STEP   = 3'd2,
        CFG_MODE         = 3'd3,
        CFG_SPIN_DIR     = 3'd4,
        CFG_STEER_GAIN   = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MODE_STRAIGHT = 2'd0,
        MODE_SPIN     = 2'd1,
        MODE_COAST    = 2'd2
    } t_mode;

    localparam logic signed [1:0] C_SPIN_CCW = 2'sb01;
    localparam logic signed [1:0] C_SPIN_CW  = 2'sb11;

    typedef struct packed {
        logic                        enable;
        t_speed                      target;
        logic [C_ACCEL_W-1:0]        accel;
        t_mode                       mode;
        logic signed [1:0]           spin_dir;
        logic signed [C_GAIN_W-1:0]  gain;
    } t_cfg;

    typedef struct packed {
        logic steer;
        logic neg_left;
        logic neg_right;
    } t_wheel_ctl;

endpackage

// File: rtl/core/trapezoid_ramp_wall_follow_speed.sv
// Top level: ramped centre speed with wall-following steering correction.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_wall_error
//  out     | output    | o_out_valid / i_out_stall| o_left_speed, o_right_speed
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One transaction per cycle unless the output stalls; an input passes the input register,
// ramp/history/product, total and magnitude, reciprocal multiply and result register
// before o_out_valid rises. Each stage holds only while its successor is full and held, so
// bubbles collapse under a stall. Synchronous active-low reset clears the
// configuration, the speed and history state and all valid bits.
module trapezoid_ramp_wall_follow_speed (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  twfs_pkg::t_err                      i_wall_error,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output twfs_pkg::t_speed                    o_left_speed,
    output twfs_pkg::t_speed                    o_right_speed,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [twfs_pkg::C_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [twfs_pkg::C_CFG_DATA_W-1:0]   i_cfg_data
);

    twfs_pkg::t_cfg          r_cfg;

    logic                    r_in_v;
    logic                    r_a_v;
    logic                    r_b_v;
    logic                    r_c_v;
    logic                    r_out_v;
    twfs_pkg::t_err          r_in_err;

    twfs_pkg::t_speed        r_b_centre;
    twfs_pkg::t_wheel_ctl    r_b_ctl;
    twfs_pkg::t_speed        r_c_centre;
    twfs_pkg::t_wheel_ctl    r_c_ctl;
    twfs_pkg::t_speed        r_left;
    twfs_pkg::t_speed        r_right;

    logic                    w_can_out;
    logic                    w_can_c;
    logic                    w_can_b;
    logic                    w_can_a;
    logic                    w_can_in;

    twfs_pkg::t_speed        w_a_centre;
    twfs_pkg::t_prod         w_a_prod;
    twfs_pkg::t_sum          w_a_sum;
    twfs_pkg::t_wheel_ctl    w_a_ctl;
    twfs_pkg::t_quot         w_quot;
    logic                    w_neg;

    twfs_pkg::t_speed        w_u;
    twfs_pkg::t_speed        n_left;
    twfs_pkg::t_speed        n_right;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                twfs_pkg::CFG_ENABLE:       r_cfg.enable   <= i_cfg_data[0];
                twfs_pkg::CFG_TARGET_SPEED: r_cfg.target   <= twfs_pkg::t_speed'(i_cfg_data);
                twfs_pkg::CFG_ACCEL_STEP: begin
                    r_cfg.accel <= i_cfg_data[twfs_pkg::C_ACCEL_W-1:0];
                end
                twfs_pkg::CFG_MODE:         r_cfg.mode     <= twfs_pkg::t_mode'(i_cfg_data[1:0]);
                twfs_pkg::CFG_SPIN_DIR:     r_cfg.spin_dir <= i_cfg_data[1:0];
                twfs_pkg::CFG_STEER_GAIN:   r_cfg.gain     <= i_cfg_data;
                default:                    r_cfg          <= r_cfg;
            endcase
        end
    end

    assign w_can_out = !r_out_v || !i_out_stall;
    assign w_can_c   = !r_c_v   || w_can_out;
    assign w_can_b   = !r_b_v   || w_can_c;
    assign w_can_a   = !r_a_v   || w_can_b;
    assign w_can_in  = !r_in_v  || w_can_a;

    assign o_in_stall = !w_can_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_a_v   <= 1'b0;
            r_b_v   <= 1'b0;
            r_c_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_can_in) begin
                r_in_v <= i_in_valid && r_cfg.enable;
            end
            if (w_can_a) begin
                r_a_v <= r_in_v;
            end
            if (w_can_b) begin
                r_b_v <= r_a_v;
            end
            if (w_can_c) begin
                r_c_v <= r_b_v;
            end
            if (w_can_out) begin
                r_out_v <= r_c_v;
            end
        end
    end

    twfs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_can_a),
        .i_valid  (r_in_v),
        .i_err    (r_in_err),
        .i_cfg    (r_cfg),
        .o_centre (w_a_centre),
        .o_prod   (w_a_prod),
        .o_sum    (w_a_sum),
        .o_ctl    (w_a_ctl)
    );

    twfs_div100 u_div (
        .i_clk    (i_clk),
        .i_load_b (w_can_b),
        .i_load_c (w_can_c),
        .i_prod   (w_a_prod),
        .i_sum    (w_a_sum),
        .o_quot   (w_quot),
        .o_neg    (w_neg)
    );

    always_comb begin
        w_u     = w_neg ? -twfs_pkg::t_speed'(w_quot) : twfs_pkg::t_speed'(w_quot);
        n_left  = r_c_centre;
        n_right = r_c_centre;
        if (r_c_ctl.steer) begin
            n_left  = r_c_centre + w_u;
            n_right = r_c_centre - w_u;
        end else if (r_c_ctl.neg_left) begin
            n_left  = -r_c_centre;
        end else if (r_c_ctl.neg_right) begin
            n_right = -r_c_centre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can_in) begin
            r_in_err <= i_wall_error;
        end
        if (w_can_b) begin
            r_b_centre <= w_a_centre;
            r_b_ctl    <= w_a_ctl;
        end
        if (w_can_c) begin
            r_c_centre <= r_b_centre;
            r_c_ctl    <= r_b_ctl;
        end
        if (w_can_out) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_left_speed  = r_left;
    assign o_right_speed = r_right;

endmodule

// File: rtl/core/twfs_front.sv
// Speed ramp, error-delta history and steering product stage.
module twfs_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_load,
    input  logic                   i_valid,
    input  twfs_pkg::t_err         i_err,
    input  twfs_pkg::t_cfg         i_cfg,
    output twfs_pkg::t_speed       o_centre,
    output twfs_pkg::t_prod        o_prod,
    output twfs_pkg::t_sum         o_sum,
    output twfs_pkg::t_wheel_ctl   o_ctl
);

    twfs_pkg::t_speed                          r_centre;
    twfs_pkg::t_err                            r_prev;
    logic signed [twfs_pkg::C_DELTA_W-1:0]     r_ring [twfs_pkg::DELTA_HISTORY];
    logic [twfs_pkg::C_PTR_W-1:0]              r_ptr;

    twfs_pkg::t_speed                          r_a_centre;
    twfs_pkg::t_prod                           r_a_prod;
    twfs_pkg::t_sum                            r_a_sum;
    twfs_pkg::t_wheel_ctl                      r_a_ctl;

    twfs_pkg::t_speed                          n_centre;
    twfs_pkg::t_speed                          w_up;
    twfs_pkg::t_speed                          w_down;
    logic signed [twfs_pkg::C_DELTA_W-1:0]     w_delta;
    logic signed [twfs_pkg::C_DELTA_W-1:0]     n_ring [twfs_pkg::DELTA_HISTORY];
    twfs_pkg::t_sum                            n_sum;
    twfs_pkg::t_prod                           n_prod;
    twfs_pkg::t_wheel_ctl                      n_ctl;
    logic                                      w_step;

    assign w_step = i_load && i_valid;

    always_comb begin
        w_up     = r_centre + twfs_pkg::t_speed'({1'b0, i_cfg.accel});
        w_down   = r_centre - twfs_pkg::t_speed'({1'b0, i_cfg.accel});
        n_centre = r_centre;
        if (r_centre < i_cfg.target) begin
            n_centre = (w_up > i_cfg.target) ? i_cfg.target : w_up;
        end else if (r_centre > i_cfg.target) begin
            n_centre = (w_down < i_cfg.target) ? i_cfg.target : w_down;
        end
    end

    always_comb begin
        w_delta = twfs_pkg::C_DELTA_W'(i_err) - twfs_pkg::C_DELTA_W'(r_prev);
        n_sum   = '0;
        for (int i = 0; i < twfs_pkg::DELTA_HISTORY; i++) begin
            n_ring[i] = (twfs_pkg::C_PTR_W'(i) == r_ptr) ? w_delta : r_ring[i];
            n_sum     = n_sum + twfs_pkg::t_sum'(n_ring[i]);
        end
        n_prod = twfs_pkg::t_prod'(i_err) * twfs_pkg::t_prod'(i_cfg.gain);
    end

    always_comb begin
        n_ctl = '0;
        case (i_cfg.mode)
            twfs_pkg::MODE_STRAIGHT: begin
                n_ctl.steer = 1'b1;
            end
            twfs_pkg::MODE_SPIN: begin
                n_ctl.neg_left  = (i_cfg.spin_dir == twfs_pkg::C_SPIN_CCW);
                n_ctl.neg_right = (i_cfg.spin_dir == twfs_pkg::C_SPIN_CW);
            end
            default: begin
                n_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre <= '0;
            r_prev   <= '0;
            r_ptr    <= '0;
            for (int i = 0; i < twfs_pkg::DELTA_HISTORY; i++) begin
                r_ring[i] <= '0;
            end
        end else if (w_step) begin
            r_centre <= n_centre;
            case (i_cfg.mode)
                twfs_pkg::MODE_STRAIGHT: begin
                    r_ring <= n_ring;
                    r_prev <= i_err;
                    r_ptr  <= r_ptr + 1'b1;
                end
                twfs_pkg::MODE_SPIN: begin
                    for (int i = 0; i < twfs_pkg::DELTA_HISTORY; i++) begin
                        r_ring[i] <= '0;
                    end
                end
                default: begin
                    r_ptr <= r_ptr;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a_centre <= n_centre;
            r_a_prod   <= n_prod;
            r_a_sum    <= n_sum;
            r_a_ctl    <= n_ctl;
        end
    end

    assign o_centre = r_a_centre;
    assign o_prod   = r_a_prod;
    assign o_sum    = r_a_sum;
    assign o_ctl    = r_a_ctl;

endmodule

// File: rtl/core/twfs_div100.sv
// Two-stage truncating divide of the steering total by the fixed divisor.
module twfs_div100 (
    input  logic               i_clk,
    input  logic               i_load_b,
    input  logic               i_load_c,
    input  twfs_pkg::t_prod    i_prod,
    input  twfs_pkg::t_sum     i_sum,
    output twfs_pkg::t_quot    o_quot,
    output logic               o_neg
);

    localparam logic [twfs_pkg::C_RECIP_W-1:0] RECIP =
        twfs_pkg::C_RECIP_W'(twfs_pkg::C_RECIP_VAL);

    logic signed [twfs_pkg::C_SCALED_W-1:0]  w_scaled;
    logic signed [twfs_pkg::C_TOTAL_W-1:0]   w_total;
    logic        [twfs_pkg::C_TOTAL_W-1:0]   w_abs;
    logic        [twfs_pkg::C_FULL_W-1:0]    w_full;

    logic        [twfs_pkg::C_MAG_W-1:0]     r_b_mag;
    logic                                    r_b_neg;
    twfs_pkg::t_quot                         r_c_quot;
    logic                                    r_c_neg;

    always_comb begin
        w_scaled = twfs_pkg::C_SCALED_W'(i_sum)
                 * twfs_pkg::C_SCALED_W'(twfs_pkg::C_SUM_SCALE);
        w_total  = twfs_pkg::C_TOTAL_W'(i_prod) + twfs_pkg::C_TOTAL_W'(w_scaled);
        w_abs    = w_total[twfs_pkg::C_TOTAL_W-1] ? -w_total : w_total;
        w_full   = twfs_pkg::C_FULL_W'(r_b_mag) * twfs_pkg::C_FULL_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_load_b) begin
            r_b_mag <= w_abs[twfs_pkg::C_MAG_W-1:0];
            r_b_neg <= w_total[twfs_pkg::C_TOTAL_W-1];
        end
        if (i_load_c) begin
            r_c_quot <= w_full[twfs_pkg::C_RECIP_SHIFT +: twfs_pkg::C_QUOT_W];
            r_c_neg  <= r_b_neg;
        end
    end

    assign o_quot = r_c_quot;
    assign o_neg  = r_c_neg;

endmodule

// File: verif/trapezoid_ramp_wall_follow_speed_test.sv
// Self-checking test of the ramped centre speed and wall steering block.
module trapezoid_ramp_wall_follow_speed_test;

    localparam int ITEM_GOAL   = 2000;
    localparam int TAIL_CYCLES = 20;

    localparam logic [twfs_pkg::C_CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd6;
    localparam logic [twfs_pkg::C_CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;
    localparam logic [1:0]                       MODE_RESERVED = 2'd3;
    localparam logic signed [1:0]                SPIN_RESERVED = 2'sb10;

    typedef struct packed {
        twfs_pkg::t_speed left;
        twfs_pkg::t_speed right;
    } t_wheel_pair;

    typedef struct packed {
        bit                                 is_write;
        logic [twfs_pkg::C_CFG_IDX_W-1:0]   index;
        logic [twfs_pkg::C_CFG_DATA_W-1:0]  data;
        twfs_pkg::t_err                     err;
        bit                                 typed;
        t_wheel_pair                        want;
    } t_step_row;

    logic                               clk;
    logic                               rst_n       = 1'b0;
    logic                               in_valid    = 1'b0;
    logic                               in_stall;
    twfs_pkg::t_err                     wall_error  = '0;
    logic                               out_valid;
    logic                               out_stall   = 1'b0;
    twfs_pkg::t_speed                   left_speed;
    twfs_pkg::t_speed                   right_speed;
    logic                               cfg_valid   = 1'b0;
    logic                               cfg_ready;
    logic [twfs_pkg::C_CFG_IDX_W-1:0]   cfg_index   = '0;
    logic [twfs_pkg::C_CFG_DATA_W-1:0]  cfg_data    = '0;

    int src_gap_pct    = 13;
    int sink_stall_pct = 62;
    int mismatches     = 0;

    twfs_pkg::t_cfg shadow_cfg = '0;
    int   speed_now      = 0;
    int   last_err       = 0;
    int   delta_hist [twfs_pkg::DELTA_HISTORY] = '{default: 0};
    int   hist_ptr       = 0;

    t_wheel_pair pending_speeds [$];
    t_wheel_pair due;
    t_step_row   steps [$];

    trapezoid_ramp_wall_follow_speed u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_wall_error  (wall_error),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_left_speed  (left_speed),
        .o_right_speed (right_speed),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int wrap_speed(input int v);
        logic signed [twfs_pkg::C_SPEED_W-1:0] w;
        w = v[twfs_pkg::C_SPEED_W-1:0];
        return int'(w);
    endfunction

    function automatic t_step_row cfg_row(input logic [twfs_pkg::C_CFG_IDX_W-1:0] idx,
                                          input logic [twfs_pkg::C_CFG_DATA_W-1:0] data);
        t_step_row r;
        r = '0;
        r.is_write = 1'b1;
        r.index    = idx;
        r.data     = data;
        return r;
    endfunction

    function automatic t_step_row tick_row(input twfs_pkg::t_err e);
        t_step_row r;
        r = '0;
        r.err = e;
        return r;
    endfunction

    function automatic t_step_row known_row(input twfs_pkg::t_err e,
                                            input twfs_pkg::t_speed l,
                                            input twfs_pkg::t_speed r_spd);
        t_step_row r;
        r = tick_row(e);
        r.typed      = 1'b1;
        r.want.left  = l;
        r.want.right = r_spd;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic predict_speeds(input twfs_pkg::t_err e, output bit emits,
                                  output t_wheel_pair res);
        int err;
        int left;
        int right;
        int total;
        int u;
        err   = int'(e);
        emits = shadow_cfg.enable;
        res   = '0;
        if (!shadow_cfg.enable)
            return;
        if (speed_now < int'(shadow_cfg.target)) begin
            speed_now = wrap_speed(speed_now + int'(shadow_cfg.accel));
            if (speed_now > int'(shadow_cfg.target))
                speed_now = int'(shadow_cfg.target);
        end else if (speed_now > int'(shadow_cfg.target)) begin
            speed_now = wrap_speed(speed_now - int'(shadow_cfg.accel));
            if (speed_now < int'(shadow_cfg.target))
                speed_now = int'(shadow_cfg.target);
        end
        left  = speed_now;
        right = speed_now;
        if (shadow_cfg.mode == twfs_pkg::MODE_STRAIGHT) begin
            delta_hist[hist_ptr] = wrap_speed(err - last_err);
            last_err = err;
            hist_ptr = (hist_ptr + 1) % twfs_pkg::DELTA_HISTORY;
            total = 0;
            for (int k = 0; k < twfs_pkg::DELTA_HISTORY; k++)
                total += delta_hist[k];
            u = wrap_speed((err * int'(shadow_cfg.gain)
                            + (twfs_pkg::C_STEER_DIV * total) / twfs_pkg::DELTA_HISTORY)
                           / twfs_pkg::C_STEER_DIV);
            left  = wrap_speed(left + u);
            right = wrap_speed(right - u);
        end else if (shadow_cfg.mode == twfs_pkg::MODE_SPIN) begin
            for (int k = 0; k < twfs_pkg::DELTA_HISTORY; k++)
                delta_hist[k] = 0;
            if (shadow_cfg.spin_dir == twfs_pkg::C_SPIN_CCW)
                left = wrap_speed(-left);
            else if (shadow_cfg.spin_dir == twfs_pkg::C_SPIN_CW)
                right = wrap_speed(-right);
        end
        res.left  = left[twfs_pkg::C_SPEED_W-1:0];
        res.right = right[twfs_pkg::C_SPEED_W-1:0];
    endtask

    task automatic write_reg(input logic [twfs_pkg::C_CFG_IDX_W-1:0] idx,
                             input logic [twfs_pkg::C_CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            twfs_pkg::CFG_ENABLE:       shadow_cfg.enable   = data[0];
            twfs_pkg::CFG_TARGET_SPEED: shadow_cfg.target   = data;
            twfs_pkg::CFG_ACCEL_STEP:   shadow_cfg.accel    = data[twfs_pkg::C_ACCEL_W-1:0];
            twfs_pkg::CFG_MODE:         shadow_cfg.mode     = twfs_pkg::t_mode'(data[1:0]);
            twfs_pkg::CFG_SPIN_DIR:     shadow_cfg.spin_dir = data[1:0];
            twfs_pkg::CFG_STEER_GAIN:   shadow_cfg.gain     = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input twfs_pkg::t_err e, input bit typed,
                             input t_wheel_pair typed_res);
        bit          emits;
        t_wheel_pair res;
        while ($urandom_range(99) < src_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        wall_error <= e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_speeds(e, emits, res);
        if (emits)
            pending_speeds.push_back(typed ? typed_res : res);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_speeds.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < sink_stall_pct);

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_speeds.size() == 0) begin
                report_mismatch("unexpected transaction, left", int'(left_speed), 0);
            end else begin
                due = pending_speeds.pop_front();
                if (left_speed !== due.left)
                    report_mismatch("left_speed", int'(left_speed), int'(due.left));
                if (right_speed !== due.right)
                    report_mismatch("right_speed", int'(right_speed), int'(due.right));
            end
        end
    end

    initial begin
        int                                 fed;
        int                                 burst;
        bit                                 ticks_pending;
        twfs_pkg::t_err                     e;
        logic [twfs_pkg::C_CFG_DATA_W-1:0]  d;

        fed           = 0;
        ticks_pending = 1'b0;

        steps.push_back(tick_row(13'sd0));
        steps.push_back(cfg_row(twfs_pkg::CFG_ENABLE, 16'd1));
        steps.push_back(known_row(13'sd0, 16'sh0000, 16'sh0000));
        steps.push_back(cfg_row(twfs_pkg::CFG_MODE, {14'd0, twfs_pkg::MODE_SPIN}));
        steps.push_back(cfg_row(twfs_pkg::CFG_SPIN_DIR, {14'd0, twfs_pkg::C_SPIN_CCW}));
        steps.push_back(cfg_row(twfs_pkg::CFG_TARGET_SPEED, 16'h8000));
        steps.push_back(cfg_row(twfs_pkg::CFG_ACCEL_STEP, 16'd16384));
        steps.push_back(known_row(13'sd0, 16'sh4000, 16'shC000));
        steps.push_back(known_row(13'sd0, 16'sh8000, 16'sh8000));
        steps.push_back(cfg_row(twfs_pkg::CFG_SPIN_DIR, {14'd0, twfs_pkg::C_SPIN_CW}));
        steps.push_back(tick_row(13'sd0));
        steps.push_back(cfg_row(twfs_pkg::CFG_SPIN_DIR, {14'd0, SPIN_RESERVED}));
        steps.push_back(tick_row(-13'sd4096));
        steps.push_back(cfg_row(twfs_pkg::CFG_ACCEL_STEP, 16'hFFFF));
        steps.push_back(cfg_row(twfs_pkg::CFG_TARGET_SPEED, 16'h7FFF));
        steps.push_back(tick_row(13'sd0));
        steps.push_back(tick_row(13'sd0));
        steps.push_back(tick_row(13'sd0));
        steps.push_back(cfg_row(twfs_pkg::CFG_MODE, {14'd0, twfs_pkg::MODE_STRAIGHT}));
        steps.push_back(cfg_row(twfs_pkg::CFG_STEER_GAIN, 16'h7FFF));
        steps.push_back(tick_row(13'sd4095));
        steps.push_back(tick_row(-13'sd4096));
        steps.push_back(tick_row(13'sd4095));
        steps.push_back(cfg_row(twfs_pkg::CFG_STEER_GAIN, 16'h8000));
        steps.push_back(tick_row(-13'sd4096));
        steps.push_back(tick_row(13'sd0));
        steps.push_back(cfg_row(twfs_pkg::CFG_MODE, {14'd0, twfs_pkg::MODE_COAST}));
        steps.push_back(tick_row(13'sd1234));
        steps.push_back(cfg_row(twfs_pkg::CFG_MODE, {14'd0, MODE_RESERVED}));
        steps.push_back(tick_row(-13'sd1));
        steps.push_back(cfg_row(CFG_SPARE_LO, 16'hFFFF));
        steps.push_back(cfg_row(CFG_SPARE_HI, 16'hFFFF));
        steps.push_back(tick_row(13'sd2047));
        steps.push_back(cfg_row(twfs_pkg::CFG_ENABLE, 16'd0));
        steps.push_back(tick_row(-13'sd2048));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (steps[n]) begin
            if (steps[n].is_write) begin
                if (ticks_pending) begin
                    settle();
                    ticks_pending = 1'b0;
                end
                write_reg(steps[n].index, steps[n].data);
            end else begin
                send_tick(steps[n].err, steps[n].typed, steps[n].want);
                ticks_pending = 1'b1;
            end
        end

        while (fed < ITEM_GOAL) begin
            if (fed < ITEM_GOAL / 3) begin
                src_gap_pct    = 13;
                sink_stall_pct = 62;
            end else if (fed < 2 * ITEM_GOAL / 3) begin
                src_gap_pct    = 62;
                sink_stall_pct = 13;
            end else begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
            settle();

            d = 16'($urandom);
            d[0] = ($urandom_range(9) != 0);
            write_reg(twfs_pkg::CFG_ENABLE, d);
            case ($urandom_range(3))
                0:       d = 16'h7FFF;
                1:       d = 16'h8000;
                default: d = 16'($urandom);
            endcase
            write_reg(twfs_pkg::CFG_TARGET_SPEED, d);
            d = 16'($urandom);
            case ($urandom_range(4))
                0:       d[twfs_pkg::C_ACCEL_W-1:0] = '1;
                1:       d[twfs_pkg::C_ACCEL_W-1:0] = '0;
                2, 3:    d[twfs_pkg::C_ACCEL_W-1:0] = 15'($urandom_range(2000));
                default: ;
            endcase
            write_reg(twfs_pkg::CFG_ACCEL_STEP, d);
            d = 16'($urandom);
            case ($urandom_range(5))
                3:       d[1:0] = twfs_pkg::MODE_SPIN;
                4:       d[1:0] = twfs_pkg::MODE_COAST;
                5:       d[1:0] = MODE_RESERVED;
                default: d[1:0] = twfs_pkg::MODE_STRAIGHT;
            endcase
            write_reg(twfs_pkg::CFG_MODE, d);
            write_reg(twfs_pkg::CFG_SPIN_DIR, 16'($urandom));
            case ($urandom_range(4))
                0:       d = 16'h7FFF;
                1:       d = 16'h8000;
                2:       d = 16'($urandom_range(400));
                default: d = 16'($urandom);
            endcase
            write_reg(twfs_pkg::CFG_STEER_GAIN, d);
            if ($urandom_range(7) == 0)
                write_reg($urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));

            burst = shadow_cfg.enable ? int'($urandom_range(40, 160)) : 6;
            repeat (burst) begin
                case ($urandom_range(7))
                    0:       e = 13'sd4095;
                    1:       e = -13'sd4096;
                    2, 3:    e = twfs_pkg::t_err'(int'($urandom_range(100)) - 50);
                    default: e = twfs_pkg::t_err'($urandom);
                endcase
                send_tick(e, 1'b0, '0);
                if (shadow_cfg.enable)
                    fed++;
            end
        end

        settle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
